// File: hw/rtl/gbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_pkg: shared types and constants of the graph bridge finder
// Sizes of the node and entry stores, command codes, stack frame layout.
// ----------------------------------------------------------------------------
package gbf_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_ENTRIES = 256;

	localparam int NW  = $clog2(MAX_NODES);    // node number bits
	localparam int CW  = NW + 1;               // node count / visit order bits
	localparam int EAW = $clog2(MAX_ENTRIES);  // entry address bits
	localparam int ECW = EAW + 1;              // entry count bits

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_RUN   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// One depth-first frame
	typedef struct packed {
		logic [NW-1:0]  node;
		logic [NW-1:0]  par;
		logic           has_par;
		logic [ECW-1:0] cursor;
		logic [CW-1:0]  low;
		logic [CW-1:0]  ord;
	} frame_t;

endpackage
`default_nettype wire

// File: hw/rtl/gbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbf_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/graph_bridge_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_bridge_finder: bridges of an undirected graph, Tarjan low-link method
// Stores adjacency entries, then walks the graph depth first on a run command
// and streams out every bridge sorted ascending by (lower, upper) node.
// ----------------------------------------------------------------------------
// Usage: clear and add transactions are taken while idle, and the block stays
// ready for the next one. A run transaction holds the input off until its last
// result is taken. The walk reads the entry memory one entry at a time, handling
// each before it fetches the next, spends an extra step on each back edge, and
// rescans the full entry list for every node it visits, then scans node pairs
// for the sorted output. node_count is to be written by the user only while the
// block is idle; the block itself does not enforce it.
module graph_bridge_finder
	import gbf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: node_count
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data,
	// input: [1:0] action, [7:2] from_node, [13:8] to_node
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,
	// output: [5:0] lower_end, [11:6] upper_end, [17:12] bridge_count
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast,   // is_last
	output logic             m_tuser    // overflow
);

	typedef enum logic [3:0] {
		S_IDLE, S_ROOT, S_EREAD, S_EWAIT, S_OCHK, S_POP, S_RWAIT,
		S_PA, S_PAW, S_PB, S_PBW, S_OUT
	} state_t;

	state_t          state_q;
	logic [6:0]      node_count_q;
	logic [ECW-1:0]  total_q;
	logic            ovf_q;
	logic [MAX_NODES-1:0] visited_q, bridge_q;
	logic [CW-1:0]   timer_q, depth_q, root_q, found_q, a_q, b_q;
	logic [NW-1:0]   emit_q, par_a_q;
	frame_t          top_q;
	logic [NW-1:0]   ch_node_q;
	logic [CW-1:0]   ch_low_q, ch_ord_q;
	logic [NW-1:0]   lo_q, hi_q;

	// Input fields
	action_t        act;
	logic [NW-1:0]  in_from, in_to;
	assign act     = action_t'(s_tdata[1:0]);
	assign in_from = s_tdata[7:2];
	assign in_to   = s_tdata[13:8];

	logic s_acc;
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Effective node count, saturated
	logic [CW-1:0] n_eff;
	assign n_eff = (node_count_q > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count_q;

	logic add_ok;
	assign add_ok = (total_q < ECW'(MAX_ENTRIES)) && ({1'b0, in_from} < n_eff)
		&& ({1'b0, in_to} < n_eff);

	// Memories
	logic [2*NW-1:0] ent_rd;
	logic [CW-1:0]   ord_rd;
	logic [NW-1:0]   par_rd;
	logic [$bits(frame_t)-1:0] stk_rd;
	frame_t          stk_fr;
	assign stk_fr = frame_t'(stk_rd);

	logic [NW-1:0] e_src, e_tgt;
	assign e_src = ent_rd[NW-1:0];
	assign e_tgt = ent_rd[2*NW-1:NW];

	// Neighbor classification
	logic v_ok, do_push, do_back;
	assign v_ok    = (e_src == top_q.node) && ({1'b0, e_tgt} < n_eff);
	assign do_push = v_ok && !visited_q[e_tgt] && (depth_q < CW'(MAX_NODES));
	assign do_back = v_ok && visited_q[e_tgt] && !(top_q.has_par && e_tgt == top_q.par);

	// Pair hit during the sorted scan
	logic hit;
	assign hit = (bridge_q[b_q[NW-1:0]] && par_rd == a_q[NW-1:0])
		|| (bridge_q[a_q[NW-1:0]] && par_a_q == b_q[NW-1:0]);

	logic [CW-1:0] t_next;
	assign t_next = timer_q + CW'(1);

	// Memory port control
	logic          ent_we, ord_we, par_we, stk_we;
	logic [EAW-1:0] ent_ra;
	logic [NW-1:0] ord_wa, ord_ra, par_wa, par_ra, stk_wa, stk_ra;
	frame_t        stk_wd;

	always_comb begin
		ent_we = s_acc && act == ACT_ADD && add_ok;
		ent_ra = top_q.cursor[EAW-1:0];
		ord_we = 1'b0;
		ord_wa = e_tgt;
		ord_ra = e_tgt;
		par_we = 1'b0;
		par_wa = e_tgt;
		par_ra = a_q[NW-1:0];
		stk_we = 1'b0;
		stk_wa = NW'(depth_q - CW'(1));
		stk_ra = NW'(depth_q - CW'(2));
		stk_wd = top_q;
		case (state_q)
			S_ROOT: begin
				ord_we = (root_q < n_eff) && !visited_q[root_q[NW-1:0]];
				ord_wa = root_q[NW-1:0];
			end
			S_EWAIT: begin
				ord_we = do_push;
				par_we = do_push;
				stk_we = do_push;
			end
			S_PB: begin
				par_ra = b_q[NW-1:0];
			end
			default: begin
			end
		endcase
	end

	gbf_ram #(.WIDTH(2*NW), .DEPTH(MAX_ENTRIES)) u_entry (
		.clk(clk), .we(ent_we), .waddr(total_q[EAW-1:0]), .wdata({in_to, in_from}),
		.raddr(ent_ra), .rdata(ent_rd)
	);

	gbf_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(t_next),
		.raddr(ord_ra), .rdata(ord_rd)
	);

	gbf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(top_q.node),
		.raddr(par_ra), .rdata(par_rd)
	);

	gbf_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd)
	);

	// Sequencer, store control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= 7'(MAX_NODES);
			total_q      <= '0;
			ovf_q        <= 1'b0;
			visited_q    <= '0;
			bridge_q     <= '0;
			timer_q      <= '0;
			depth_q      <= '0;
			root_q       <= '0;
			found_q      <= '0;
			emit_q       <= '0;
			a_q          <= '0;
			b_q          <= '0;
			par_a_q      <= '0;
			top_q        <= '0;
			ch_node_q    <= '0;
			ch_low_q     <= '0;
			ch_ord_q     <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			m_tvalid     <= 1'b0;
			m_tlast      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						case (act)
							ACT_CLEAR: begin
								total_q <= '0;
								ovf_q   <= 1'b0;
							end
							ACT_ADD: begin
								if (add_ok) total_q <= total_q + ECW'(1);
								else ovf_q <= 1'b1;
							end
							ACT_RUN: begin
								visited_q <= '0;
								bridge_q  <= '0;
								timer_q   <= '0;
								root_q    <= '0;
								found_q   <= '0;
								emit_q    <= '0;
								state_q   <= S_ROOT;
							end
							default: begin
							end
						endcase
					end
				end
				// next unvisited root, or on to the output scan (or one empty result if no bridge was found)
				S_ROOT: begin
					if (root_q >= n_eff) begin
						a_q <= '0;
						if (found_q == '0) begin
							lo_q     <= '0;
							hi_q     <= '0;
							m_tvalid <= 1'b1;
							m_tlast  <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_PA;
						end
					end else if (visited_q[root_q[NW-1:0]]) begin
						root_q <= root_q + CW'(1);
					end else begin
						visited_q[root_q[NW-1:0]] <= 1'b1;
						timer_q        <= t_next;
						top_q.node     <= root_q[NW-1:0];
						top_q.par      <= '0;
						top_q.has_par  <= 1'b0;
						top_q.cursor   <= '0;
						top_q.low      <= t_next;
						top_q.ord      <= t_next;
						depth_q        <= CW'(1);
						state_q        <= S_EREAD;
					end
				end
				// fetch next stored entry for the top node, or pop it at the end of the list
				S_EREAD: begin
					if (top_q.cursor < total_q) begin
						top_q.cursor <= top_q.cursor + ECW'(1);
						state_q      <= S_EWAIT;
					end else begin
						state_q <= S_POP;
					end
				end
				S_EWAIT: begin
					if (do_push) begin
						visited_q[e_tgt] <= 1'b1;
						timer_q        <= t_next;
						top_q.node     <= e_tgt;
						top_q.par      <= top_q.node;
						top_q.has_par  <= 1'b1;
						top_q.cursor   <= '0;
						top_q.low      <= t_next;
						top_q.ord      <= t_next;
						depth_q        <= depth_q + CW'(1);
						state_q        <= S_EREAD;
					end else if (do_back) begin
						state_q <= S_OCHK;
					end else begin
						state_q <= S_EREAD;
					end
				end
				// back edge: fold in the neighbor's visit order
				S_OCHK: begin
					if (ord_rd < top_q.low) top_q.low <= ord_rd;
					state_q <= S_EREAD;
				end
				S_POP: begin
					ch_node_q <= top_q.node;
					ch_low_q  <= top_q.low;
					ch_ord_q  <= top_q.ord;
					depth_q   <= depth_q - CW'(1);
					if (depth_q == CW'(1)) begin
						root_q  <= root_q + CW'(1);
						state_q <= S_ROOT;
					end else begin
						state_q <= S_RWAIT;
					end
				end
				// restore parent frame, test the tree edge
				S_RWAIT: begin
					top_q <= stk_fr;
					if (ch_low_q < stk_fr.low) top_q.low <= ch_low_q;
					if (ch_low_q >= ch_ord_q) begin
						bridge_q[ch_node_q] <= 1'b1;
						found_q <= found_q + CW'(1);
					end
					state_q <= S_EREAD;
				end
				S_PA: begin
					state_q <= S_PAW;
				end
				S_PAW: begin
					par_a_q <= par_rd;
					b_q     <= a_q + CW'(1);
					state_q <= S_PB;
				end
				S_PB: begin
					if (b_q >= n_eff) begin
						a_q     <= a_q + CW'(1);
						state_q <= S_PA;
					end else begin
						state_q <= S_PBW;
					end
				end
				S_PBW: begin
					if (hit) begin
						lo_q     <= a_q[NW-1:0];
						hi_q     <= b_q[NW-1:0];
						m_tvalid <= 1'b1;
						m_tlast  <= (CW'(emit_q) + CW'(1) == found_q);
						emit_q   <= emit_q + NW'(1);
						state_q  <= S_OUT;
					end else begin
						b_q     <= b_q + CW'(1);
						state_q <= S_PB;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= S_IDLE;
						end else begin
							b_q     <= b_q + CW'(1);
							state_q <= S_PB;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tdata = {6'd0, found_q[NW-1:0], hi_q, lo_q};
	assign m_tuser = ovf_q;

	// Checks
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("output pending while idle");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CW'(MAX_NODES)) else $error("stack depth overrun");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		found_q < CW'(MAX_NODES)) else $error("bridge count overrun");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && found_q != '0) |-> (CW'(emit_q) == found_q))
		else $error("last result before all bridges sent");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ECW'(MAX_ENTRIES)) else $error("entry count overrun");

endmodule
`default_nettype wire
